FILE: src/weighted_flow_path_selector_macros.svh
// Assertion helpers for the weighted flow path selector
`ifndef WEIGHTED_FLOW_PATH_SELECTOR_MACROS_SVH
`define WEIGHTED_FLOW_PATH_SELECTOR_MACROS_SVH

// same-cycle implication
`define WFPS_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WFPS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/wfps_pkg.sv
package wfps_pkg;

   localparam int WEIGHT_W   = 16;
   localparam int TOTAL_W    = 18;
   localparam int HASH_W     = 6;
   localparam int PATH_W     = 2;
   localparam int MASK_W     = 4;
   localparam int NUM_REGS   = 4;
   localparam int NUM_PATHS  = 4;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_W      = 3;

   typedef logic [PATH_W-1:0]   path_type;
   typedef logic [WEIGHT_W-1:0] weight_type;
   typedef logic [TOTAL_W-1:0]  total_type;

   localparam path_type PATH_LAST = PATH_W'(NUM_PATHS - 1);

   // register indexes
   localparam logic [REG_W-1:0] REG_WEIGHT0  = 3'd0;
   localparam logic [REG_W-1:0] REG_WEIGHT1  = 3'd1;
   localparam logic [REG_W-1:0] REG_WEIGHT2  = 3'd2;
   localparam logic [REG_W-1:0] REG_WEIGHT3  = 3'd3;
   localparam logic [REG_W-1:0] REG_UP       = 3'd4;
   localparam logic [REG_W-1:0] REG_ATTACHED = 3'd5;

   // commands
   localparam logic CMD_REBUILD = 1'b0;
   localparam logic CMD_ROUTE   = 1'b1;

   localparam logic [MASK_W-1:0] UP_MASK_RESET = 4'hF;

endpackage

FILE: src/weighted_flow_path_selector.sv
// Route request: the table read is registered on accept and S_READ then loads the result;
//   no new request is taken until the result is loaded, which waits while a result is unaccepted.
// Rebuild request: a bit-serial divider (one quotient bit per cycle) sizes each path's share,
//   then the flow table is filled with one table write per cycle.
// Reset: registers to defaults, counters zero; the table reads path zero until the first
//   rebuild completes (no clearing pass).
`include "weighted_flow_path_selector_macros.svh"

module weighted_flow_path_selector
   import wfps_pkg::*;
#(
   parameter int FLOW_SLOTS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [5:0] flow_hash
   input  logic                  req_tuser,   // [0] command
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [1:0] path_id, [2] drop
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int IDX_W  = $clog2(FLOW_SLOTS);
   localparam int CNT_W  = $clog2(FLOW_SLOTS + 1);
   localparam int NUM_W  = WEIGHT_W + CNT_W;
   localparam int DCNT_W = $clog2(NUM_W + 1);
   localparam int REM_W  = TOTAL_W + 1;
   localparam int SUM_W  = $clog2(FLOW_SLOTS + (2 ** HASH_W));
   localparam int CHK_W  = CNT_W + 2;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PREP = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_FILL = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;
   localparam logic [2:0] S_READ = 3'd5;

   // configuration
   weight_type              weight_ff [NUM_REGS];
   logic [MASK_W-1:0]       up_mask_ff, up_mask_in;
   logic [MASK_W-1:0]       attached_mask_ff, attached_mask_in;
   logic                    csr_we;
   logic [REG_W-1:0]        csr_idx;

   // control
   logic [2:0]              state_ff, state_in;
   total_type               total_weight_ff, total_weight_in;
   total_type               packets_left_ff, packets_left_in;
   logic [IDX_W-1:0]        rotation_ff, rotation_in;
   logic                    built_ff, built_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // rebuild datapath
   total_type               calc_total_ff, calc_total_in;
   path_type                best_ff, best_in;
   path_type                cur_ff, cur_in;
   logic [NUM_W-1:0]        num_ff, num_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]        quot_ff, quot_in;
   logic [DCNT_W-1:0]       div_cnt_ff, div_cnt_in;
   logic [CNT_W-1:0]        pos_ff, pos_in;
   logic [CNT_W-1:0]        left_ff, left_in;
   logic [CNT_W-1:0]        fill_cnt_ff, fill_cnt_in;
   path_type                fill_path_ff, fill_path_in;
   logic                    last_fill_ff, last_fill_in;

   // response payload
   path_type                rsp_path_ff, rsp_path_in;
   logic                    rsp_drop_ff, rsp_drop_in;

   // flow table memory
   path_type                table_mem [FLOW_SLOTS];
   path_type                rd_data_ff;
   logic                    tbl_we;
   logic                    tbl_re;
   logic [IDX_W-1:0]        rd_addr;

   // combinational helpers
   weight_type              eff_w [NUM_REGS];
   total_type               sum_total;
   path_type                sum_best;
   weight_type              best_w;
   logic [REM_W-1:0]        rem_sh;
   logic                    rem_ge;
   path_type                next_cur;
   logic [CNT_W-1:0]        q_clamp;
   logic [IDX_W-1:0]        rot_new;
   logic [SUM_W-1:0]        addr_sum;
   path_type                path_sel;
   logic                    req_fire;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_drop_ff, rsp_path_ff};

   // ------------------------------------------------------------------ CSR
   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      csr_prdata = '0;
      case (csr_idx)
         REG_WEIGHT0:  csr_prdata = CSR_DATA_W'(weight_ff[0]);
         REG_WEIGHT1:  csr_prdata = CSR_DATA_W'(weight_ff[1]);
         REG_WEIGHT2:  csr_prdata = CSR_DATA_W'(weight_ff[2]);
         REG_WEIGHT3:  csr_prdata = CSR_DATA_W'(weight_ff[3]);
         REG_UP:       csr_prdata = CSR_DATA_W'(up_mask_ff);
         REG_ATTACHED: csr_prdata = CSR_DATA_W'(attached_mask_ff);
         default:      csr_prdata = '0;
      endcase
   end

   always_comb begin
      up_mask_in       = up_mask_ff;
      attached_mask_in = attached_mask_ff;
      if (csr_we && csr_idx == REG_UP) begin
         up_mask_in = csr_pwdata[MASK_W-1:0];
      end
      if (csr_we && csr_idx == REG_ATTACHED) begin
         attached_mask_in = csr_pwdata[MASK_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            weight_ff[i] <= '0;
         end
         up_mask_ff       <= UP_MASK_RESET;
         attached_mask_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_REGS; i++) begin
            if (csr_we && csr_idx == REG_W'(i)) begin
               weight_ff[i] <= csr_pwdata[WEIGHT_W-1:0];
            end
         end
         up_mask_ff       <= up_mask_in;
         attached_mask_ff <= attached_mask_in;
      end
   end

   // ---------------------------------------------------- weight summary
   always_comb begin
      sum_total = '0;
      sum_best  = '0;
      best_w    = '0;
      for (int p = 0; p < NUM_REGS; p++) begin
         eff_w[p] = (p < NUM_PATHS && up_mask_ff[p]) ? weight_ff[p] : '0;
         sum_total = sum_total + TOTAL_W'(eff_w[p]);
         if (eff_w[p] > best_w) begin
            best_w   = eff_w[p];
            sum_best = PATH_W'(p);
         end
      end
   end

   // divider step and fill helpers
   assign rem_sh   = {rem_ff[TOTAL_W-1:0], num_ff[NUM_W-1]};
   assign rem_ge   = (rem_sh >= {1'b0, calc_total_ff});
   assign next_cur = (cur_ff == PATH_LAST) ? '0 : cur_ff + 1'b1;
   assign q_clamp  = (quot_ff > left_ff) ? left_ff : quot_ff;

   // route address: (rotation + hash) mod FLOW_SLOTS
   always_comb begin
      if (packets_left_ff == '0) begin
         rot_new = (rotation_ff == IDX_W'(FLOW_SLOTS - 1)) ? '0 : rotation_ff + 1'b1;
      end else begin
         rot_new = rotation_ff;
      end
      addr_sum = SUM_W'(rot_new) + SUM_W'(req_tdata[HASH_W-1:0]);
      for (int i = 0; i < 4; i++) begin
         if (addr_sum >= SUM_W'(FLOW_SLOTS)) begin
            addr_sum = addr_sum - SUM_W'(FLOW_SLOTS);
         end
      end
      rd_addr = addr_sum[IDX_W-1:0];
   end

   assign tbl_we   = (state_ff == S_FILL) && (fill_cnt_ff != '0);
   assign tbl_re   = req_fire && (req_tuser == CMD_ROUTE);
   assign path_sel = built_ff ? rd_data_ff : '0;

   // ------------------------------------------------------- sequencer
   always_comb begin
      state_in        = state_ff;
      total_weight_in = total_weight_ff;
      packets_left_in = packets_left_ff;
      rotation_in     = rotation_ff;
      built_in        = built_ff;
      rsp_valid_in    = rsp_valid_ff;
      calc_total_in   = calc_total_ff;
      best_in         = best_ff;
      cur_in          = cur_ff;
      num_in          = num_ff;
      rem_in          = rem_ff;
      quot_in         = quot_ff;
      div_cnt_in      = div_cnt_ff;
      pos_in          = pos_ff;
      left_in         = left_ff;
      fill_cnt_in     = fill_cnt_ff;
      fill_path_in    = fill_path_ff;
      last_fill_in    = last_fill_ff;
      rsp_path_in     = rsp_path_ff;
      rsp_drop_in     = rsp_drop_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_tuser == CMD_REBUILD) begin
                  state_in = S_PREP;
               end else begin
                  rotation_in = rot_new;
                  if (packets_left_ff == '0) begin
                     packets_left_in = total_weight_ff;
                  end else begin
                     packets_left_in = packets_left_ff - 1'b1;
                  end
                  state_in = S_READ;
               end
            end
         end
         S_PREP: begin
            calc_total_in = sum_total;
            best_in       = sum_best;
            cur_in        = sum_best;
            pos_in        = '0;
            if (sum_total == '0) begin
               fill_path_in = sum_best;
               fill_cnt_in  = CNT_W'(FLOW_SLOTS);
               left_in      = '0;
               last_fill_in = 1'b1;
               state_in     = S_FILL;
            end else begin
               left_in    = CNT_W'(FLOW_SLOTS);
               num_in     = NUM_W'(eff_w[sum_best]) * NUM_W'(FLOW_SLOTS);
               rem_in     = '0;
               quot_in    = '0;
               div_cnt_in = DCNT_W'(NUM_W);
               state_in   = S_DIV;
            end
         end
         S_DIV: begin
            if (div_cnt_ff != '0) begin
               rem_in     = rem_ge ? rem_sh - {1'b0, calc_total_ff} : rem_sh;
               quot_in    = {quot_ff[CNT_W-2:0], rem_ge};
               num_in     = {num_ff[NUM_W-2:0], 1'b0};
               div_cnt_in = div_cnt_ff - 1'b1;
            end else begin
               fill_cnt_in  = q_clamp;
               left_in      = left_ff - q_clamp;
               fill_path_in = cur_ff;
               last_fill_in = 1'b0;
               state_in     = S_FILL;
            end
         end
         S_FILL: begin
            if (fill_cnt_ff != '0) begin
               pos_in      = pos_ff + 1'b1;
               fill_cnt_in = fill_cnt_ff - 1'b1;
            end else if (last_fill_ff || left_ff == '0) begin
               state_in = S_DONE;
            end else if (next_cur == best_ff) begin
               // leftover slots go to the heaviest path
               cur_in       = next_cur;
               fill_path_in = best_ff;
               fill_cnt_in  = left_ff;
               left_in      = '0;
               last_fill_in = 1'b1;
            end else begin
               cur_in     = next_cur;
               num_in     = NUM_W'(eff_w[next_cur]) * NUM_W'(FLOW_SLOTS);
               rem_in     = '0;
               quot_in    = '0;
               div_cnt_in = DCNT_W'(NUM_W);
               state_in   = S_DIV;
            end
         end
         S_DONE: begin
            if (calc_total_ff != total_weight_ff) begin
               total_weight_in = calc_total_ff;
               packets_left_in = '0;
            end
            built_in = 1'b1;
            state_in = S_IDLE;
         end
         S_READ: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_path_in  = path_sel;
               rsp_drop_in  = !attached_mask_ff[path_sel];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         total_weight_ff <= '0;
         packets_left_ff <= '0;
         rotation_ff     <= '0;
         built_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         total_weight_ff <= total_weight_in;
         packets_left_ff <= packets_left_in;
         rotation_ff     <= rotation_in;
         built_ff        <= built_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      calc_total_ff <= calc_total_in;
      best_ff       <= best_in;
      cur_ff        <= cur_in;
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      quot_ff       <= quot_in;
      div_cnt_ff    <= div_cnt_in;
      pos_ff        <= pos_in;
      left_ff       <= left_in;
      fill_cnt_ff   <= fill_cnt_in;
      fill_path_ff  <= fill_path_in;
      last_fill_ff  <= last_fill_in;
      rsp_path_ff   <= rsp_path_in;
      rsp_drop_ff   <= rsp_drop_in;
   end

   // flow table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         table_mem[pos_ff[IDX_W-1:0]] <= fill_path_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_re) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   // ------------------------------------------------------- assertions
   `WFPS_ASSERT_IMP(a_fill_in_range, clock, reset, tbl_we, pos_ff < CNT_W'(FLOW_SLOTS), "table write beyond last slot")
   `WFPS_ASSERT_IMP(a_done_full, clock, reset, state_ff == S_DONE, pos_ff == CNT_W'(FLOW_SLOTS), "rebuild ended before every slot was written")
   `WFPS_ASSERT_IMP(a_fill_balance, clock, reset, state_ff == S_FILL, (CHK_W'(pos_ff) + CHK_W'(fill_cnt_ff) + CHK_W'(left_ff)) == CHK_W'(FLOW_SLOTS), "slot accounting mismatch")
   `WFPS_ASSERT_NEXT(a_result_loaded, clock, reset, (state_ff == S_READ) && (!rsp_valid_ff || rsp_tready), rsp_valid_ff, "route result not presented")

endmodule

FILE: tb/tb.sv
module tb;
   import wfps_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FLOW_SLOTS    = 64;
   localparam int SETTLE_CYCLES = 300;
   localparam int WATCHDOG_MAX  = 5000;
   localparam int HOLD_CYCLES   = 400;
   localparam int NO_IDLE_PHASE = 7;
   localparam int HOLD_PHASE    = 10;
   localparam int LAST_PHASE    = 16;
   localparam int PHASE_ITEMS   = 45;

   typedef struct packed {
      logic              cmd;
      logic [HASH_W-1:0] hash;
   } path_req_type;

   typedef struct packed {
      path_type path;
      logic     drop;
   } route_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;   // [5:0] flow_hash
   logic                  req_tuser = 1'b0; // [0] command
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;        // [1:0] path_id, [2] drop
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // local copy of block state
   weight_type      path_weight [NUM_PATHS];
   logic [MASK_W-1:0] up_bits;
   logic [MASK_W-1:0] attach_bits;
   path_type        flow_slot [FLOW_SLOTS];
   total_type       total_wt;
   total_type       countdown;
   logic [HASH_W-1:0] rotation;

   path_req_type     pending_reqs[$];
   route_result_type expected_routes[$];

   logic req_taken = 1'b0;
   int   mismatch_count = 0;
   int   idle_pct = 24;
   int   phase_no = 0;
   int   hold_left = 0;
   bit   hold_done = 1'b0;
   int   quiet_cycles = 0;

   weighted_flow_path_selector #(
      .FLOW_SLOTS(FLOW_SLOTS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #4 clock = ~clock;

   function automatic weight_type effective_weight(int p);
      if (up_bits[p]) return path_weight[p];
      return '0;
   endfunction

   function automatic void rebuild_table();
      total_type  sum;
      weight_type w;
      weight_type best_w;
      int         best_p;
      int         p;
      int         slot;
      int         left;
      int         share;
      sum = '0;
      best_w = '0;
      best_p = 0;
      for (int i = 0; i < NUM_PATHS; i++) begin
         w = effective_weight(i);
         sum += w;
         if (w > best_w) begin
            best_w = w;
            best_p = i;
         end
      end
      p = best_p;
      slot = 0;
      left = FLOW_SLOTS;
      if (sum != 0) begin
         do begin
            share = int'((longint'(effective_weight(p)) * FLOW_SLOTS) / longint'(sum));
            if (share > left) share = left;
            left -= share;
            while (share > 0 && slot < FLOW_SLOTS) begin
               flow_slot[slot] = path_type'(p);
               slot++;
               share--;
            end
            p = (p + 1) % NUM_PATHS;
         end while (left != 0 && p != best_p);
      end
      // leftover slots go to the heaviest path
      while (left > 0 && slot < FLOW_SLOTS) begin
         flow_slot[slot] = path_type'(p);
         slot++;
         left--;
      end
      if (sum != total_wt) begin
         total_wt = sum;
         countdown = '0;
      end
   endfunction

   function automatic route_result_type route_packet(logic [HASH_W-1:0] hash);
      route_result_type  res;
      logic [HASH_W-1:0] idx;
      if (countdown == 0) begin
         countdown = total_wt;
         rotation = rotation + 1'b1;
      end else begin
         countdown = countdown - 1'b1;
      end
      idx = rotation + hash;
      res.path = flow_slot[idx];
      res.drop = ~attach_bits[res.path];
      return res;
   endfunction

   function automatic weight_type pick_weight();
      case ($urandom_range(3))
         0: return '0;
         1: return weight_type'($urandom_range(1, 6));
         2: return '1;
         default: return weight_type'($urandom_range(65535));
      endcase
   endfunction

   task automatic push_req(logic cmd, logic [HASH_W-1:0] hash);
      path_req_type r;
      r.cmd = cmd;
      r.hash = hash;
      pending_reqs.push_back(r);
   endtask

   task automatic csr_write(logic [REG_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(idx) << 2;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      case (idx)
         REG_WEIGHT0, REG_WEIGHT1, REG_WEIGHT2, REG_WEIGHT3:
            path_weight[idx[PATH_W-1:0]] = value[WEIGHT_W-1:0];
         REG_UP: up_bits = value[MASK_W-1:0];
         REG_ATTACHED: attach_bits = value[MASK_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_paths(weight_type w0, weight_type w1, weight_type w2, weight_type w3,
                            logic [MASK_W-1:0] up, logic [MASK_W-1:0] att);
      csr_write(REG_WEIGHT0, CSR_DATA_W'(w0));
      csr_write(REG_WEIGHT1, CSR_DATA_W'(w1));
      csr_write(REG_WEIGHT2, CSR_DATA_W'(w2));
      csr_write(REG_WEIGHT3, CSR_DATA_W'(w3));
      csr_write(REG_UP, CSR_DATA_W'(up));
      csr_write(REG_ATTACHED, CSR_DATA_W'(att));
   endtask

   // wait for all requests and routes, then let a rebuild finish
   task automatic drain();
      while (pending_reqs.size() != 0 || req_tvalid || expected_routes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(negedge clock) begin : drive_req
      path_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
            nxt = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {2'b00, nxt.hash};
            req_tuser <= nxt.cmd;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (phase_no == HOLD_PHASE && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin : check_routes
      route_result_type want;
      route_result_type got;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.path = rsp_tdata[1:0];
            got.drop = rsp_tdata[2];
            if (expected_routes.size() == 0) begin
               $display("%0t: unexpected route result path %0d drop %0d", $realtime, got.path,
                        got.drop);
               mismatch_count++;
            end else begin
               want = expected_routes.pop_front();
               if (got.path != want.path) begin
                  $display("%0t: path_id expected %0d actual %0d", $realtime, want.path,
                           got.path);
                  mismatch_count++;
               end
               if (got.drop != want.drop) begin
                  $display("%0t: drop expected %0d actual %0d", $realtime, want.drop, got.drop);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == CMD_ROUTE)
               expected_routes.push_back(route_packet(req_tdata[HASH_W-1:0]));
            else
               rebuild_table();
         end
         req_taken <= req_tvalid && req_tready;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("%0t: no progress for %0d cycles", $realtime, quiet_cycles);
         $display("weighted_flow_path_selector verification failed");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < NUM_PATHS; i++) path_weight[i] = '0;
      for (int i = 0; i < FLOW_SLOTS; i++) flow_slot[i] = '0;
      up_bits = UP_MASK_RESET;
      attach_bits = '0;
      total_wt = '0;
      countdown = '0;
      rotation = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset table, then rebuild with zero total
      push_req(CMD_ROUTE, 6'd0);
      push_req(CMD_ROUTE, 6'd63);
      push_req(CMD_REBUILD, 6'd0);
      push_req(CMD_ROUTE, 6'd5);
      drain();

      // small weights, then a rebuild that keeps the same total
      phase_no = 1;
      set_paths(16'd1, 16'd2, 16'd3, 16'd4, 4'hF, 4'hF);
      push_req(CMD_REBUILD, 6'd0);
      push_req(CMD_ROUTE, 6'd0);
      push_req(CMD_ROUTE, 6'd63);
      push_req(CMD_ROUTE, 6'd31);
      push_req(CMD_REBUILD, 6'd63);
      push_req(CMD_ROUTE, 6'd1);
      drain();

      phase_no = 2;
      set_paths('1, '1, '1, '1, 4'hF, 4'h5);
      push_req(CMD_REBUILD, 6'd0);
      push_req(CMD_ROUTE, 6'd0);
      push_req(CMD_ROUTE, 6'd63);
      push_req(CMD_ROUTE, 6'd42);
      drain();

      // only weighted path is down: zero total
      phase_no = 3;
      set_paths('0, '0, '0, 16'd7, 4'b0111, 4'b1000);
      push_req(CMD_REBUILD, 6'd0);
      push_req(CMD_ROUTE, 6'd10);
      push_req(CMD_ROUTE, 6'd20);
      drain();

      // tie between paths one and two, path zero down
      phase_no = 4;
      set_paths(16'd5, 16'd9, 16'd9, 16'd2, 4'b1110, 4'b0110);
      push_req(CMD_REBUILD, 6'd0);
      push_req(CMD_ROUTE, 6'd0);
      push_req(CMD_ROUTE, 6'd21);
      push_req(CMD_ROUTE, 6'd47);
      push_req(CMD_ROUTE, 6'd63);
      drain();

      for (int ph = 5; ph <= LAST_PHASE; ph++) begin
         phase_no = ph;
         idle_pct = (ph == NO_IDLE_PHASE) ? 0 : 24;
         set_paths(pick_weight(), pick_weight(), pick_weight(), pick_weight(),
                   MASK_W'($urandom_range(15)), MASK_W'($urandom_range(15)));
         if ($urandom_range(99) < 80) push_req(CMD_REBUILD, HASH_W'($urandom_range(63)));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(99) < 12)
               push_req(CMD_REBUILD, HASH_W'($urandom_range(63)));
            else
               push_req(CMD_ROUTE, HASH_W'($urandom_range(63)));
         end
         drain();
      end

      if (mismatch_count == 0) begin
         $display("weighted_flow_path_selector verification clean");
      end else begin
         $display("weighted_flow_path_selector verification failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+src
src/wfps_pkg.sv
src/weighted_flow_path_selector.sv
tb/tb.sv
